### src/esca_pkg.sv
// ============================================================================
// esca_pkg
// Shared types, widths and constants of the event scan accumulator.
// ============================================================================
package esca_pkg;

    // store depth, a power of two
    localparam int MAX_POSITIONS = 65536;
    localparam int TIME_SCALE    = 25;
    localparam int ADDR_W        = $clog2(MAX_POSITIONS);

    // field widths
    localparam int TIME_W   = 48;
    localparam int PIX_W    = 16;
    localparam int POS_W    = 16;
    localparam int DOSE_W   = 32;
    localparam int SUM_W    = 40;
    localparam int RING_W   = 32;
    localparam int LINE_W   = 48;
    localparam int DWELL_W  = 16;
    localparam int DIM_W    = 11;
    localparam int CTR_W    = 14;
    localparam int SQ_W     = 28;
    localparam int MASK_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;

    // derived widths
    localparam int SCALED_W = TIME_W + $clog2(TIME_SCALE + 1);
    localparam int DEN_W    = DWELL_W;
    localparam int STEP_W   = $clog2(SCALED_W + 1);
    localparam int SLOT_W   = 2 * DIM_W;
    localparam int KY_W     = PIX_W;
    localparam int DX_W     = DIM_W + 5;
    localparam int DY_W     = KY_W + 5;
    localparam int D2_W     = 2 * DY_W;

    // command queue between front and back
    localparam int CMDQ_DEPTH = 2;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DWELL_DIVISOR,
        REG_SCAN_WIDTH,
        REG_SCAN_HEIGHT,
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_RING_INNER_SQ,
        REG_RING_OUTER_SQ,
        REG_ENABLE_MASK
    } cfg_index_t;

    typedef struct packed {
        logic [DWELL_W-1:0] dwell_divisor;
        logic [DIM_W-1:0]   scan_width;
        logic [DIM_W-1:0]   scan_height;
        logic [CTR_W-1:0]   center_x;
        logic [CTR_W-1:0]   center_y;
        logic [SQ_W-1:0]    ring_inner_sq;
        logic [SQ_W-1:0]    ring_outer_sq;
        logic [MASK_W-1:0]  enable_mask;
    } cfg_t;

    typedef struct packed {
        logic              operation;
        logic [TIME_W-1:0] arrival_time;
        logic [PIX_W-1:0]  pixel_index;
        logic [POS_W-1:0]  read_address;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [DOSE_W-1:0] dose_count;
        logic [SUM_W-1:0]  sum_x;
        logic [SUM_W-1:0]  sum_y;
        logic [RING_W-1:0] ring_count;
        logic [LINE_W-1:0] line_number;
        logic              line_advanced;
    } result_t;

    // divider request and response
    typedef struct packed {
        logic                start;
        logic [SCALED_W-1:0] num;
        logic [DEN_W-1:0]    den;
        logic [STEP_W-1:0]   steps;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [SCALED_W-1:0] quo;
        logic [DEN_W-1:0]    rem;
    } div_rsp_t;

    // classified transaction handed from front to back
    typedef struct packed {
        logic              is_read;
        logic              adv;
        logic              ring_hit;
        logic [SLOT_W-1:0] slot;
        logic [DIM_W-1:0]  kx;
        logic [KY_W-1:0]   ky;
        logic [SLOT_W-1:0] row_base;
        logic [DIM_W-1:0]  row_len;
        logic [LINE_W-1:0] line;
    } cmd_t;

endpackage

### src/event_scan_com_accumulator.sv
// ============================================================================
// event_scan_com_accumulator
// Places hit events into scan slots and accumulates dose, kx and ky sums
// and an annular count per slot; a read transaction returns a slot.
// ============================================================================
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------
//  input    | push / full         | item   (item_t)
//  result   | pop / empty         | result (result_t)
//  config   | cfg_we              | cfg_index, cfg_data
//
// a hit transaction holds the front through its divisions on the
// one-bit-per-cycle divider (53 quotient bits, 16 for the pixel split), plus
// one more division when the line advances; the back then reads and updates
// the slot, first clearing a row of scan-width entries when the line advances.
// a read transaction skips the divider and goes straight to the push state of
// the front; when the back is free it reads the slot and registers the result.
// after reset the back sweeps all MAX_POSITIONS entries to zero and full
// stays high meanwhile.
// a waiting result holds the back; the front runs on until the two-entry
// command queue fills.
module event_scan_com_accumulator
    import esca_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  item_t                 item,
    output logic                  full,
    output logic                  empty,
    input  logic                  pop,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t     cfg_reg;
    div_req_t div_req;
    div_rsp_t div_rsp;
    cmd_t     front_cmd;
    cmd_t     queue_cmd;
    logic     front_push;
    logic     queue_full;
    logic     queue_empty;
    logic     back_pop;
    logic     init_done;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dwell_divisor <= DWELL_W'(1);
            cfg_reg.scan_width    <= DIM_W'(256);
            cfg_reg.scan_height   <= DIM_W'(256);
            cfg_reg.center_x      <= CTR_W'(2048);
            cfg_reg.center_y      <= CTR_W'(2048);
            cfg_reg.ring_inner_sq <= '0;
            cfg_reg.ring_outer_sq <= '1;
            cfg_reg.enable_mask   <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_DWELL_DIVISOR: cfg_reg.dwell_divisor <= cfg_data[DWELL_W-1:0];
                REG_SCAN_WIDTH:    cfg_reg.scan_width    <= cfg_data[DIM_W-1:0];
                REG_SCAN_HEIGHT:   cfg_reg.scan_height   <= cfg_data[DIM_W-1:0];
                REG_CENTER_X:      cfg_reg.center_x      <= cfg_data[CTR_W-1:0];
                REG_CENTER_Y:      cfg_reg.center_y      <= cfg_data[CTR_W-1:0];
                REG_RING_INNER_SQ: cfg_reg.ring_inner_sq <= cfg_data[SQ_W-1:0];
                REG_RING_OUTER_SQ: cfg_reg.ring_outer_sq <= cfg_data[SQ_W-1:0];
                REG_ENABLE_MASK:   cfg_reg.enable_mask   <= cfg_data[MASK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // shared divider
    esca_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // front: accept and classify
    esca_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .ready    (init_done),
        .cfg      (cfg_reg),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .cmd      (front_cmd),
        .cmd_push (front_push),
        .cmd_full (queue_full)
    );

    // command queue
    esca_cmd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .din   (front_cmd),
        .full  (queue_full),
        .pop   (back_pop),
        .dout  (queue_cmd),
        .empty (queue_empty)
    );

    // back: stores and results
    esca_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (queue_cmd),
        .cmd_empty   (queue_empty),
        .cmd_pop     (back_pop),
        .enable_mask (cfg_reg.enable_mask),
        .init_done   (init_done),
        .result      (result),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

### src/esca_div.sv
// ============================================================================
// esca_div
// Restoring divider, one quotient bit per cycle, shared by the front.
// ============================================================================
module esca_div
    import esca_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   cnt_reg;
    logic [SCALED_W-1:0] num_reg;
    logic [SCALED_W-1:0] quo_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [DEN_W:0]      trial;
    logic [DEN_W:0]      diff;
    logic                ge;

    // one trial subtraction
    always_comb
    begin
        trial = {rem_reg, num_reg[SCALED_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[SCALED_W-2:0], 1'b0};
            quo_reg <= {quo_reg[SCALED_W-2:0], ge};
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

### src/esca_front.sv
// ============================================================================
// esca_front
// Accepts transactions, finds slot, detector coordinates, line advance and
// ring test, and hands a classified command to the back.
// ============================================================================
module esca_front
    import esca_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  item_t    item,
    output logic     full,
    input  logic     ready,
    input  cfg_t     cfg,
    output div_req_t div_req,
    input  div_rsp_t div_rsp,
    output cmd_t     cmd,
    output logic     cmd_push,
    input  logic     cmd_full
);

    typedef enum logic [3:0] {
        F_IDLE,
        F_DIV_T,
        F_DIV_W,
        F_DIV_H,
        F_DIV_P,
        F_LINE,
        F_DIV_R,
        F_RING,
        F_CMP,
        F_PUSH
    } state_t;

    state_t              state_reg;
    logic [LINE_W-1:0]   lc_reg;
    div_req_t            req_reg;
    cmd_t                cmd_reg;
    logic [PIX_W-1:0]    pix_reg;
    logic [SCALED_W-1:0] q_reg;
    logic [DIM_W-1:0]    r_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [DIM_W-1:0]    kx_reg;
    logic [KY_W-1:0]     ky_reg;
    logic                adv_reg;
    logic [SLOT_W-1:0]   row_base_reg;
    logic [D2_W-1:0]     dxsq_reg;
    logic [D2_W-1:0]     dysq_reg;

    logic [DIM_W-1:0]    w_nz;
    logic [DIM_W-1:0]    h_nz;
    logic [DWELL_W-1:0]  d_nz;
    logic [SCALED_W-1:0] scaled;
    logic [LINE_W-1:0]   line_inc;
    logic [SCALED_W-1:0] row_num;
    logic signed [DX_W-1:0]   dx;
    logic signed [DY_W-1:0]   dy;
    logic signed [2*DX_W-1:0] dx_prod;
    logic signed [D2_W-1:0]   dy_prod;
    logic [D2_W-1:0]     d2;
    logic                hit;
    logic                accept;

    // operand preparation
    always_comb
    begin
        w_nz     = (cfg.scan_width == '0) ? DIM_W'(1) : cfg.scan_width;
        h_nz     = (cfg.scan_height == '0) ? DIM_W'(1) : cfg.scan_height;
        d_nz     = (cfg.dwell_divisor == '0) ? DWELL_W'(1) : cfg.dwell_divisor;
        scaled   = SCALED_W'(item.arrival_time) * SCALED_W'(TIME_SCALE);
        line_inc = lc_reg + LINE_W'(1);
        row_num  = SCALED_W'(line_inc) + SCALED_W'(1);
        dx       = $signed({1'b0, kx_reg, 4'b0}) - $signed(DX_W'(cfg.center_x));
        dy       = $signed({1'b0, ky_reg, 4'b0}) - $signed(DY_W'(cfg.center_y));
        dx_prod  = dx * dx;
        dy_prod  = dy * dy;
        d2       = dxsq_reg + dysq_reg;
        hit      = (d2 > D2_W'(cfg.ring_inner_sq)) && (d2 <= D2_W'(cfg.ring_outer_sq));
        accept   = push && !full;
    end

    assign full     = (state_reg != F_IDLE) || !ready;
    assign cmd_push = (state_reg == F_PUSH) && !cmd_full;
    assign cmd      = cmd_reg;
    assign div_req  = req_reg;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            lc_reg       <= '0;
            req_reg      <= '0;
            cmd_reg      <= '0;
            pix_reg      <= '0;
            q_reg        <= '0;
            r_reg        <= '0;
            slot_reg     <= '0;
            kx_reg       <= '0;
            ky_reg       <= '0;
            adv_reg      <= 1'b0;
            row_base_reg <= '0;
            dxsq_reg     <= '0;
            dysq_reg     <= '0;
        end
        else
        begin
            // start is a one-cycle pulse; no request is issued while it is high
            if (req_reg.start)
            begin
                req_reg.start <= 1'b0;
            end
            case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        pix_reg <= item.pixel_index;
                        if (item.operation)
                        begin
                            cmd_reg.is_read  <= 1'b1;
                            cmd_reg.adv      <= 1'b0;
                            cmd_reg.ring_hit <= 1'b0;
                            cmd_reg.slot     <= SLOT_W'(item.read_address);
                            cmd_reg.kx       <= '0;
                            cmd_reg.ky       <= '0;
                            cmd_reg.row_base <= '0;
                            cmd_reg.row_len  <= '0;
                            cmd_reg.line     <= lc_reg;
                            state_reg        <= F_PUSH;
                        end
                        else
                        begin
                            req_reg   <= '{1'b1, scaled, DEN_W'(d_nz), STEP_W'(SCALED_W)};
                            state_reg <= F_DIV_T;
                        end
                    end
                end
                // scaled time over dwell gives the total position
                F_DIV_T:
                begin
                    if (div_rsp.done)
                    begin
                        req_reg   <= '{1'b1, div_rsp.quo, DEN_W'(w_nz), STEP_W'(SCALED_W)};
                        state_reg <= F_DIV_W;
                    end
                end
                // total over width gives line and column
                F_DIV_W:
                begin
                    if (div_rsp.done)
                    begin
                        q_reg     <= div_rsp.quo;
                        r_reg     <= div_rsp.rem[DIM_W-1:0];
                        req_reg   <= '{1'b1, div_rsp.quo, DEN_W'(h_nz), STEP_W'(SCALED_W)};
                        state_reg <= F_DIV_H;
                    end
                end
                // line modulo height gives the image row
                F_DIV_H:
                begin
                    if (div_rsp.done)
                    begin
                        slot_reg  <= SLOT_W'(div_rsp.rem[DIM_W-1:0]) * SLOT_W'(w_nz)
                                     + SLOT_W'(r_reg);
                        req_reg   <= '{1'b1, {pix_reg, {(SCALED_W-PIX_W){1'b0}}},
                                       DEN_W'(w_nz), STEP_W'(PIX_W)};
                        state_reg <= F_DIV_P;
                    end
                end
                // pixel index split into kx and ky
                F_DIV_P:
                begin
                    if (div_rsp.done)
                    begin
                        kx_reg    <= div_rsp.rem[DIM_W-1:0];
                        ky_reg    <= div_rsp.quo[KY_W-1:0];
                        state_reg <= F_LINE;
                    end
                end
                // line advance check
                F_LINE:
                begin
                    if (q_reg > SCALED_W'(lc_reg))
                    begin
                        lc_reg    <= line_inc;
                        adv_reg   <= 1'b1;
                        req_reg   <= '{1'b1, row_num, DEN_W'(h_nz), STEP_W'(SCALED_W)};
                        state_reg <= F_DIV_R;
                    end
                    else
                    begin
                        adv_reg   <= 1'b0;
                        state_reg <= F_RING;
                    end
                end
                // row to clear
                F_DIV_R:
                begin
                    if (div_rsp.done)
                    begin
                        row_base_reg <= SLOT_W'(div_rsp.rem[DIM_W-1:0]) * SLOT_W'(w_nz);
                        state_reg    <= F_RING;
                    end
                end
                // squared offsets
                F_RING:
                begin
                    dxsq_reg  <= D2_W'($unsigned(dx_prod));
                    dysq_reg  <= $unsigned(dy_prod);
                    state_reg <= F_CMP;
                end
                F_CMP:
                begin
                    cmd_reg.is_read  <= 1'b0;
                    cmd_reg.adv      <= adv_reg;
                    cmd_reg.ring_hit <= hit;
                    cmd_reg.slot     <= slot_reg;
                    cmd_reg.kx       <= kx_reg;
                    cmd_reg.ky       <= ky_reg;
                    cmd_reg.row_base <= row_base_reg;
                    cmd_reg.row_len  <= w_nz;
                    cmd_reg.line     <= lc_reg;
                    state_reg        <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!cmd_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

### src/esca_cmd_queue.sv
// ============================================================================
// esca_cmd_queue
// Short command queue between front and back.
// ============================================================================
module esca_cmd_queue
    import esca_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t din,
    output logic full,
    input  logic pop,
    output cmd_t dout,
    output logic empty
);

    localparam int QP_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;

    cmd_t            q_mem [CMDQ_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg;
    logic [QP_W-1:0] rd_ptr_reg;
    logic [QP_W:0]   count_reg;

    assign full  = (count_reg == (QP_W+1)'(CMDQ_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = q_mem[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QP_W'(CMDQ_DEPTH - 1)) ? '0
                              : wr_ptr_reg + QP_W'(1);
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QP_W'(CMDQ_DEPTH - 1)) ? '0
                              : rd_ptr_reg + QP_W'(1);
            end
            if ((push && !full) && !(pop && !empty))
            begin
                count_reg <= count_reg + (QP_W+1)'(1);
            end
            else if (!(push && !full) && (pop && !empty))
            begin
                count_reg <= count_reg - (QP_W+1)'(1);
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            q_mem[wr_ptr_reg] <= din;
        end
    end

endmodule

### src/esca_back.sv
// ============================================================================
// esca_back
// Accumulator stores: clearing pass, row clears, read-modify-write and reads.
// ============================================================================
module esca_back
    import esca_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    input  logic              cmd_empty,
    output logic              cmd_pop,
    input  logic [MASK_W-1:0] enable_mask,
    output logic              init_done,
    output result_t           result,
    output logic              empty,
    input  logic              pop
);

    typedef enum logic [2:0] {
        B_INIT,
        B_IDLE,
        B_CLEAR,
        B_READ,
        B_UPD
    } state_t;

    typedef struct packed {
        logic [DOSE_W-1:0] dose;
        logic [SUM_W-1:0]  sx;
        logic [SUM_W-1:0]  sy;
    } acc_t;

    acc_t              acc_mem  [MAX_POSITIONS];
    logic [RING_W-1:0] ring_mem [MAX_POSITIONS];

    state_t            state_reg;
    cmd_t              cmd_reg;
    logic [ADDR_W-1:0] init_cnt_reg;
    logic [DIM_W-1:0]  clr_cnt_reg;
    acc_t              rd_acc_reg;
    logic [RING_W-1:0] rd_ring_reg;
    result_t           out_reg;
    logic              out_valid_reg;

    logic              we_a;
    logic              we_r;
    logic              re;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    acc_t              wdata_a;
    logic [RING_W-1:0] wdata_r;
    logic [SUM_W:0]    sx_sum;
    logic [SUM_W:0]    sy_sum;
    acc_t              new_acc;
    logic [RING_W-1:0] new_ring;
    acc_t              res_acc;
    logic [RING_W-1:0] res_ring;

    // saturating update of the slot
    always_comb
    begin
        sx_sum           = {1'b0, rd_acc_reg.sx} + (SUM_W+1)'(cmd_reg.kx);
        sy_sum           = {1'b0, rd_acc_reg.sy} + (SUM_W+1)'(cmd_reg.ky);
        new_acc.dose     = (rd_acc_reg.dose == '1) ? rd_acc_reg.dose
                           : rd_acc_reg.dose + DOSE_W'(1);
        new_acc.sx       = sx_sum[SUM_W] ? '1 : sx_sum[SUM_W-1:0];
        new_acc.sy       = sy_sum[SUM_W] ? '1 : sy_sum[SUM_W-1:0];
        new_ring         = (rd_ring_reg == '1) ? rd_ring_reg : rd_ring_reg + RING_W'(1);
        if (!enable_mask[0])
        begin
            new_acc = rd_acc_reg;
        end
        if (!(enable_mask[1] && cmd_reg.ring_hit))
        begin
            new_ring = rd_ring_reg;
        end
        res_acc  = cmd_reg.is_read ? rd_acc_reg : new_acc;
        res_ring = cmd_reg.is_read ? rd_ring_reg : new_ring;
    end

    // memory port control
    always_comb
    begin
        we_a    = 1'b0;
        we_r    = 1'b0;
        re      = 1'b0;
        waddr   = '0;
        raddr   = ADDR_W'(cmd_reg.slot);
        wdata_a = '0;
        wdata_r = '0;
        cmd_pop = 1'b0;
        case (state_reg)
            B_INIT:
            begin
                we_a  = 1'b1;
                we_r  = 1'b1;
                waddr = init_cnt_reg;
            end
            B_IDLE:
            begin
                cmd_pop = !cmd_empty && !out_valid_reg;
            end
            B_CLEAR:
            begin
                we_a  = enable_mask[0];
                we_r  = enable_mask[1];
                waddr = ADDR_W'(cmd_reg.row_base + SLOT_W'(clr_cnt_reg));
            end
            B_READ:
            begin
                re = 1'b1;
            end
            B_UPD:
            begin
                we_a    = !cmd_reg.is_read && enable_mask[0];
                we_r    = !cmd_reg.is_read && enable_mask[1] && cmd_reg.ring_hit;
                waddr   = ADDR_W'(cmd_reg.slot);
                wdata_a = new_acc;
                wdata_r = new_ring;
            end
            default:
            begin
            end
        endcase
    end

    // stores
    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            acc_mem[waddr] <= wdata_a;
        end
        if (we_r)
        begin
            ring_mem[waddr] <= wdata_r;
        end
        if (re)
        begin
            rd_acc_reg  <= acc_mem[raddr];
            rd_ring_reg <= ring_mem[raddr];
        end
    end

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_INIT;
            init_cnt_reg  <= '0;
            clr_cnt_reg   <= '0;
            cmd_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_INIT:
                begin
                    init_cnt_reg <= init_cnt_reg + ADDR_W'(1);
                    if (init_cnt_reg == '1)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                B_IDLE:
                begin
                    if (cmd_pop)
                    begin
                        cmd_reg     <= cmd;
                        clr_cnt_reg <= '0;
                        state_reg   <= cmd.adv ? B_CLEAR : B_READ;
                    end
                end
                B_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + DIM_W'(1);
                    if (clr_cnt_reg == cmd_reg.row_len - DIM_W'(1))
                    begin
                        state_reg <= B_READ;
                    end
                end
                B_READ:
                begin
                    state_reg <= B_UPD;
                end
                B_UPD:
                begin
                    out_reg.position      <= POS_W'(cmd_reg.slot);
                    out_reg.dose_count    <= res_acc.dose;
                    out_reg.sum_x         <= res_acc.sx;
                    out_reg.sum_y         <= res_acc.sy;
                    out_reg.ring_count    <= res_ring;
                    out_reg.line_number   <= cmd_reg.line;
                    out_reg.line_advanced <= cmd_reg.adv;
                    out_valid_reg         <= 1'b1;
                    state_reg             <= B_IDLE;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign init_done = (state_reg != B_INIT);
    assign result    = out_reg;
    assign empty     = !out_valid_reg;

endmodule

### bench/esca_checker.sv
// ============================================================================
// esca_checker
// Watches the input, result and config channels of the event scan
// accumulator, predicts every result and compares it with what comes out.
// ============================================================================
module esca_checker
    import esca_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  item_t                 item,
    input  logic                  full,
    input  logic                  empty,
    input  logic                  pop,
    input  result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    waiting,
    output int                    hit_count,
    output int                    read_count,
    output int                    advance_count
);

    // shadow of the accumulator stores and the line counter
    logic [DOSE_W-1:0] dose_mem [MAX_POSITIONS];
    logic [SUM_W-1:0]  sumx_mem [MAX_POSITIONS];
    logic [SUM_W-1:0]  sumy_mem [MAX_POSITIONS];
    logic [RING_W-1:0] ring_mem [MAX_POSITIONS];
    logic [LINE_W-1:0] line_ctr;

    // shadow of the settings
    cfg_t settings;

    // results still owed by the block
    result_t owed_results [$];

    assign waiting = owed_results.size();

    // read one slot into a result
    function automatic result_t slot_snapshot(longint unsigned slot, logic adv);
        result_t r;
        r.position      = POS_W'(slot);
        r.dose_count    = dose_mem[slot];
        r.sum_x         = sumx_mem[slot];
        r.sum_y         = sumy_mem[slot];
        r.ring_count    = ring_mem[slot];
        r.line_number   = line_ctr;
        r.line_advanced = adv;
        return r;
    endfunction

    // apply one transaction to the shadow state and return its result
    function automatic result_t scan_event(item_t it);
        longint unsigned w, h, dv, total, slot, kx, ky, row, a, d2;
        longint          dx, dy;
        logic            adv;
        w   = (settings.scan_width == 0) ? 1 : settings.scan_width;
        h   = (settings.scan_height == 0) ? 1 : settings.scan_height;
        dv  = (settings.dwell_divisor == 0) ? 1 : settings.dwell_divisor;
        adv = 1'b0;
        if (it.operation)
        begin
            read_count++;
            return slot_snapshot(it.read_address, 1'b0);
        end
        hit_count++;
        total = (64'(it.arrival_time) * TIME_SCALE) / dv;
        slot  = (total % (w * h)) % MAX_POSITIONS;
        kx    = it.pixel_index % w;
        ky    = it.pixel_index / w;
        // line advance clears the row after the new line
        if (total / w > 64'(line_ctr))
        begin
            line_ctr = line_ctr + 1'b1;
            row      = (64'(line_ctr) + 1) % h;
            for (longint unsigned i = 0; i < w; i++)
            begin
                a = (row * w + i) % MAX_POSITIONS;
                if (settings.enable_mask[0])
                begin
                    dose_mem[a] = '0;
                    sumx_mem[a] = '0;
                    sumy_mem[a] = '0;
                end
                if (settings.enable_mask[1])
                    ring_mem[a] = '0;
            end
            adv = 1'b1;
            advance_count++;
        end
        // saturating accumulation
        if (settings.enable_mask[0])
        begin
            if (dose_mem[slot] != '1)
                dose_mem[slot] = dose_mem[slot] + 1'b1;
            sumx_mem[slot] = (41'(sumx_mem[slot]) + kx > 41'({SUM_W{1'b1}})) ?
                             '1 : sumx_mem[slot] + SUM_W'(kx);
            sumy_mem[slot] = (41'(sumy_mem[slot]) + ky > 41'({SUM_W{1'b1}})) ?
                             '1 : sumy_mem[slot] + SUM_W'(ky);
        end
        // annular test in Q.4
        if (settings.enable_mask[1])
        begin
            dx = longint'(kx * 16) - longint'(settings.center_x);
            dy = longint'(ky * 16) - longint'(settings.center_y);
            d2 = dx * dx + dy * dy;
            if (d2 > settings.ring_inner_sq && d2 <= settings.ring_outer_sq
                && ring_mem[slot] != '1)
                ring_mem[slot] = ring_mem[slot] + 1'b1;
        end
        return slot_snapshot(slot, adv);
    endfunction

    // channel monitor
    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_POSITIONS; i++)
            begin
                dose_mem[i] = '0;
                sumx_mem[i] = '0;
                sumy_mem[i] = '0;
                ring_mem[i] = '0;
            end
            line_ctr               = '0;
            settings.dwell_divisor = 1;
            settings.scan_width    = 256;
            settings.scan_height   = 256;
            settings.center_x      = 2048;
            settings.center_y      = 2048;
            settings.ring_inner_sq = 0;
            settings.ring_outer_sq = '1;
            settings.enable_mask   = 2'b11;
            owed_results.delete();
            fail_count    = 0;
            hit_count     = 0;
            read_count    = 0;
            advance_count = 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    REG_DWELL_DIVISOR: settings.dwell_divisor = cfg_data[DWELL_W-1:0];
                    REG_SCAN_WIDTH:    settings.scan_width    = cfg_data[DIM_W-1:0];
                    REG_SCAN_HEIGHT:   settings.scan_height   = cfg_data[DIM_W-1:0];
                    REG_CENTER_X:      settings.center_x      = cfg_data[CTR_W-1:0];
                    REG_CENTER_Y:      settings.center_y      = cfg_data[CTR_W-1:0];
                    REG_RING_INNER_SQ: settings.ring_inner_sq = cfg_data[SQ_W-1:0];
                    REG_RING_OUTER_SQ: settings.ring_outer_sq = cfg_data[SQ_W-1:0];
                    REG_ENABLE_MASK:   settings.enable_mask   = cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end
            // accepted input transaction
            if (push && !full)
                owed_results.push_back(scan_event(item));
            // accepted result transaction
            if (pop && !empty)
            begin
                if (owed_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: pos=%0h dose=%0h", result.position,
                                 result.dose_count);
                end
                else
                begin
                    exp_r = owed_results.pop_front();
                    if (result !== exp_r)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("mismatch exp: pos=%h dose=%h sx=%h sy=%h ring=%h line=%h adv=%b",
                                     exp_r.position, exp_r.dose_count, exp_r.sum_x,
                                     exp_r.sum_y, exp_r.ring_count, exp_r.line_number,
                                     exp_r.line_advanced);
                            $display("         act: pos=%h dose=%h sx=%h sy=%h ring=%h line=%h adv=%b",
                                     result.position, result.dose_count, result.sum_x,
                                     result.sum_y, result.ring_count, result.line_number,
                                     result.line_advanced);
                        end
                    end
                end
            end
        end
    end

endmodule

### bench/testbench.sv
// ============================================================================
// testbench
// Drives hit and read transactions into the event scan accumulator under a
// series of register settings, with random gaps on both channels; the
// checker predicts and compares every result.
// ============================================================================
module testbench;
    import esca_pkg::*;

    localparam int CYCLE_LIMIT = 10000000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  push      = 1'b0;
    item_t                 item      = '0;
    logic                  full;
    logic                  empty;
    logic                  pop       = 1'b0;
    result_t               result;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count, waiting, hit_count, read_count, advance_count;
    int cycles     = 0;
    int pop_gap    = 0;

    // current settings as the stimulus sees them
    longint unsigned width_now  = 256;
    longint unsigned height_now = 256;
    longint unsigned dwell_now  = 1;
    longint unsigned scan_time  = 0;

    always #5 clk = ~clk;

    event_scan_com_accumulator dut (
        .clk, .rst_n, .push, .item, .full, .empty, .pop, .result,
        .cfg_we, .cfg_index, .cfg_data
    );

    esca_checker u_checker (
        .clk, .rst_n, .push, .item, .full, .empty, .pop, .result,
        .cfg_we, .cfg_index, .cfg_data,
        .fail_count, .waiting, .hit_count, .read_count, .advance_count
    );

    // mostly short gaps, some long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(20, 150);
    endfunction

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side with random stalls
    always @(posedge clk)
    begin
        int g;
        if (pop_gap > 0)
        begin
            pop     <= 1'b0;
            pop_gap <= pop_gap - 1;
        end
        else if (pop && !empty)
        begin
            g        = pick_gap();
            pop_gap <= g;
            pop     <= (g == 0);
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    // one input transaction, then an optional gap; push stays high without one
    task automatic send(item_t it);
        int gap;
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // wait for all results, then let the back settle before register writes
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_settings(cfg_t s);
        logic [CFG_DATA_W-1:0] vals [8];
        vals[REG_DWELL_DIVISOR] = CFG_DATA_W'(s.dwell_divisor);
        vals[REG_SCAN_WIDTH]    = CFG_DATA_W'(s.scan_width);
        vals[REG_SCAN_HEIGHT]   = CFG_DATA_W'(s.scan_height);
        vals[REG_CENTER_X]      = CFG_DATA_W'(s.center_x);
        vals[REG_CENTER_Y]      = CFG_DATA_W'(s.center_y);
        vals[REG_RING_INNER_SQ] = CFG_DATA_W'(s.ring_inner_sq);
        vals[REG_RING_OUTER_SQ] = CFG_DATA_W'(s.ring_outer_sq);
        vals[REG_ENABLE_MASK]   = CFG_DATA_W'(s.enable_mask);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        width_now  = (s.scan_width == 0) ? 1 : s.scan_width;
        height_now = (s.scan_height == 0) ? 1 : s.scan_height;
        dwell_now  = (s.dwell_divisor == 0) ? 1 : s.dwell_divisor;
    endtask

    function automatic item_t hit_item(longint unsigned t, int pix);
        item_t it;
        it.operation    = 1'b0;
        it.arrival_time = TIME_W'(t);
        it.pixel_index  = PIX_W'(pix);
        it.read_address = POS_W'($urandom);
        return it;
    endfunction

    function automatic item_t read_item(int addr);
        item_t it;
        it.operation    = 1'b1;
        it.arrival_time = TIME_W'({$urandom, $urandom});
        it.pixel_index  = PIX_W'($urandom);
        it.read_address = POS_W'(addr);
        return it;
    endfunction

    // random transaction: mostly a scan stream, some reads and wild times
    function automatic item_t random_item();
        int              r, pix;
        longint unsigned span, step_max, pix_max;
        r    = $urandom_range(0, 99);
        span = width_now * height_now;
        if (span > MAX_POSITIONS)
            span = MAX_POSITIONS;
        if (r < 15)
            return read_item(($urandom_range(0, 9) < 6) ? $urandom_range(0, 32'(span - 1))
                                                        : $urandom_range(0, 65535));
        pix_max = (width_now * width_now > 65535) ? 65535 : width_now * width_now - 1;
        pix = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 32'(pix_max))
                                          : $urandom_range(0, 65535);
        if (r < 21)
            return hit_item({$urandom, $urandom}, pix);
        step_max  = dwell_now * 8 / TIME_SCALE + 2;
        scan_time = scan_time + $urandom_range(0, 32'(step_max));
        return hit_item(scan_time, pix);
    endfunction

    function automatic cfg_t random_settings();
        cfg_t s;
        logic [SQ_W-1:0] a, b;
        s.dwell_divisor = ($urandom_range(0, 1) == 0) ? DWELL_W'($urandom_range(1, 50))
                                                      : DWELL_W'($urandom_range(1, 65535));
        s.scan_width    = ($urandom_range(0, 4) == 0) ? DIM_W'($urandom_range(65, 300))
                                                      : DIM_W'($urandom_range(1, 64));
        s.scan_height   = DIM_W'($urandom_range(1, 64));
        s.center_x      = CTR_W'($urandom_range(0, 16383));
        s.center_y      = CTR_W'($urandom_range(0, 16383));
        a               = SQ_W'($urandom >> $urandom_range(4, 31));
        b               = SQ_W'($urandom >> $urandom_range(4, 31));
        s.ring_inner_sq = (a < b) ? a : b;
        s.ring_outer_sq = (a < b) ? b : a;
        s.enable_mask   = MASK_W'($urandom_range(0, 3));
        return s;
    endfunction

    initial
    begin
        cfg_t s;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed at reset settings: field extremes and reads
        send(read_item(0));
        send(read_item(65535));
        send(hit_item(0, 0));
        send(hit_item(0, 65535));
        send(hit_item(48'hFFFF_FFFF_FFFF, 65535));
        send(hit_item(48'hFFFF_FFFF_FFFF, 0));
        send(hit_item(10, 300));
        send(hit_item(10, 300));
        send(read_item(250));
        send(read_item(0));
        drain();

        // ring boundaries: distance zero, exactly outer, just beyond
        s = '{dwell_divisor: 1, scan_width: 256, scan_height: 256, center_x: 2048,
              center_y: 2048, ring_inner_sq: 0, ring_outer_sq: 256, enable_mask: 3};
        write_settings(s);
        send(hit_item(4, 128 * 256 + 128));
        send(hit_item(4, 128 * 256 + 129));
        send(hit_item(4, 128 * 256 + 130));
        send(hit_item(4, 127 * 256 + 128));
        send(read_item(100));
        drain();
        s.ring_inner_sq = 256;
        s.ring_outer_sq = 1024;
        write_settings(s);
        send(hit_item(4, 128 * 256 + 129));
        send(hit_item(4, 128 * 256 + 130));
        send(hit_item(4, 128 * 256 + 131));
        send(read_item(100));
        drain();

        // extreme settings, then random ones
        for (int phase = 0; phase < 13; phase++)
        begin
            int n;
            n = 160;
            case (phase)
                0: s = '{dwell_divisor: 0, scan_width: 1, scan_height: 1, center_x: 0,
                         center_y: 0, ring_inner_sq: 0, ring_outer_sq: '1, enable_mask: 0};
                1: begin
                    s = '{dwell_divisor: 65535, scan_width: 1024, scan_height: 1024,
                          center_x: 16383, center_y: 0, ring_inner_sq: '1,
                          ring_outer_sq: '1, enable_mask: 1};
                    n = 30;
                end
                2: s = '{dwell_divisor: 1, scan_width: 0, scan_height: 0, center_x: 0,
                         center_y: 16383, ring_inner_sq: 0, ring_outer_sq: '1,
                         enable_mask: 2};
                3: s = '{dwell_divisor: 1, scan_width: 2, scan_height: 1024,
                         center_x: 16, center_y: 16, ring_inner_sq: 0,
                         ring_outer_sq: 0, enable_mask: 3};
                default: s = random_settings();
            endcase
            write_settings(s);
            scan_time = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} >> 20 : 0;
            for (int k = 0; k < n; k++)
                send(random_item());
            drain();
        end

        $display("covered %0d hits, %0d reads, %0d line advances", hit_count, read_count,
                 advance_count);
        $display("over default, ring-boundary, extreme and random register settings");
        if (fail_count == 0 && waiting == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
